// ===== rtl/pfll_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-source failure lockout limiter package
// Shared constants, codes, slot record layout and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package pfll_pkg;

   localparam int NUM_SLOTS_DEF = 8;

   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 8;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int US_W    = 20;
   localparam int SPAN_W  = CSR_W + US_W;

   localparam logic [US_W-1:0]    US_PER_SECOND = US_W'(1000000);
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

   // Register reset values.
   localparam logic [7:0]  MAX_ATTEMPTS_RST    = 8'd5;
   localparam logic [15:0] WINDOW_SECONDS_RST  = 16'd30;
   localparam logic [15:0] LOCKOUT_SECONDS_RST = 16'd60;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATTEMPTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_SECONDS = 2'd2;

   // Command codes.
   localparam logic [1:0] CMD_CHECK   = 2'd0;
   localparam logic [1:0] CMD_FAIL    = 2'd1;
   localparam logic [1:0] CMD_SUCCESS = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  source;
      logic [TIME_W-1:0]  window_start;
      logic [COUNT_W-1:0] strikes;
      logic [TIME_W-1:0]  last_seen;
      logic [TIME_W-1:0]  lockout_end;
   } slot_rec_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic rd_en;
      logic scan_eval;
      logic pick;
      logic upd1;
      logic wr_en;
      logic rsp_load;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       enabled;
      logic       rsp_busy;
   } dp_status_type;

endpackage

// ===== rtl/pfll_ifs.sv =====
// ----------------------------------------------------------------------------
// Limiter channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfll_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] source_addr;
   logic [63:0] now_time;

   modport source(output valid, cmd, source_addr, now_time, input ready);
   modport sink(input valid, cmd, source_addr, now_time, output ready);
endinterface

interface pfll_rsp_if;
   logic valid;
   logic ready;
   logic allowed;
   logic entry_found;

   modport source(output valid, allowed, entry_found, input ready);
   modport sink(input valid, allowed, entry_found, output ready);
endinterface

// ===== rtl/per_source_failure_lockout_limiter.sv =====
// Every transfer is answered after the table scan, which reads one slot per cycle, and the decision step;
// if the limiter is enabled, a failure also passes two update steps before its response is loaded.
// One request is worked on at a time; the next is taken once the last response is loaded.
// A finished response waits in its own register, so the next request is taken meanwhile.
// Reset is synchronous and active high: it empties the table and restores the register defaults.
// ----------------------------------------------------------------------------
// Per-source failure lockout limiter
// Tracks failed attempts per source address in a small table and locks a
// source out for a while once it has failed too often within a window.
// ----------------------------------------------------------------------------
module per_source_failure_lockout_limiter #(
   parameter int NUM_SLOTS = pfll_pkg::NUM_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   pfll_req_if.sink                       req_ch,
   pfll_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [pfll_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfll_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // The controller walks the table one slot per cycle; the datapath keeps
   // the first matching entry, the first free slot and the least recently
   // seen slot as the scan goes by. After the scan, the decision step picks
   // the target slot and computes the check verdict; with the limiter enabled, a
   // failure then uses two update steps to check the window and write the entry.
   pfll_pkg::dp_cmd_type    dp_cmd;
   pfll_pkg::dp_status_type dp_status;
   logic [IDX_W-1:0]        scan_addr;
   logic                    req_ready;

   pfll_ctrl #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd),
      .scan_addr (scan_addr)
   );

   pfll_dp #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_ch.cmd),
      .req_source_addr (req_ch.source_addr),
      .req_now_time    (req_ch.now_time),
      .cmd             (dp_cmd),
      .scan_addr       (scan_addr),
      .status          (dp_status),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_allowed     (rsp_ch.allowed),
      .rsp_entry_found (rsp_ch.entry_found)
   );

   // The request side is ready only while the controller is idle.
   assign req_ch.ready = req_ready;

endmodule

// ===== rtl/pfll_dp.sv =====
// ----------------------------------------------------------------------------
// Limiter datapath
// Configuration registers, slot table memory, scan accumulators, entry
// update arithmetic and the response register.
// ----------------------------------------------------------------------------
module pfll_dp #(
   parameter int NUM_SLOTS = pfll_pkg::NUM_SLOTS_DEF,
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pfll_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfll_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [1:0]                       req_cmd,
   input  logic [pfll_pkg::ADDR_W-1:0]      req_source_addr,
   input  logic [pfll_pkg::TIME_W-1:0]      req_now_time,
   input  pfll_pkg::dp_cmd_type             cmd,
   input  logic [IDX_W-1:0]                 scan_addr,
   output pfll_pkg::dp_status_type          status,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_allowed,
   output logic                             rsp_entry_found
);

   localparam int TW = pfll_pkg::TIME_W;
   localparam int SW = pfll_pkg::SPAN_W;

   logic [7:0]  max_att_ff;
   logic [15:0] win_sec_ff;
   logic [15:0] lock_sec_ff;
   logic [SW-1:0] win_span_ff;
   logic [SW-1:0] lock_span_ff;

   logic [1:0]    op_ff;
   logic [31:0]   addr_ff;
   logic [TW-1:0] now_ff;
   logic [TW-1:0] lock_end_ff;

   pfll_pkg::slot_rec_type mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   valid_ff;
   pfll_pkg::slot_rec_type rd_data_ff;
   logic [IDX_W-1:0]       rd_idx_ff;

   logic                   found_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   pfll_pkg::slot_rec_type hit_rec_ff;
   logic                   free_any_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   lru_any_ff;
   logic [IDX_W-1:0]       lru_idx_ff;
   logic [TW-1:0]          lru_time_ff;

   logic [IDX_W-1:0]       tgt_idx_ff;
   pfll_pkg::slot_rec_type work_rec_ff;
   logic                   allowed_ff;
   logic                   gt_ff;
   logic [TW-1:0]          diff_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_allowed_ff;
   logic                   rsp_found_ff;

   logic                   rd_valid;
   logic                   restart;
   logic [7:0]             base_count;
   logic [7:0]             new_count;
   pfll_pkg::slot_rec_type new_rec;
   pfll_pkg::slot_rec_type fresh_rec;

   // Configuration registers and the spans derived from them.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_att_ff  <= pfll_pkg::MAX_ATTEMPTS_RST;
         win_sec_ff  <= pfll_pkg::WINDOW_SECONDS_RST;
         lock_sec_ff <= pfll_pkg::LOCKOUT_SECONDS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            pfll_pkg::CSR_MAX_ATTEMPTS:    max_att_ff  <= csr_wdata[7:0];
            pfll_pkg::CSR_WINDOW_SECONDS:  win_sec_ff  <= csr_wdata;
            pfll_pkg::CSR_LOCKOUT_SECONDS: lock_sec_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      win_span_ff  <= SW'(win_sec_ff) * SW'(pfll_pkg::US_PER_SECOND);
      lock_span_ff <= SW'(lock_sec_ff) * SW'(pfll_pkg::US_PER_SECOND);
      lock_end_ff  <= now_ff + TW'(lock_span_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_cmd;
         addr_ff <= req_source_addr;
         now_ff  <= req_now_time;
      end
   end

   // Slot table: one read port for the scan, one write port for updates.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[scan_addr];
         rd_idx_ff  <= scan_addr;
      end
      if (cmd.wr_en) begin
         mem[tgt_idx_ff] <= new_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[tgt_idx_ff] <= 1'b1;
      end else if (cmd.pick && op_ff == pfll_pkg::CMD_SUCCESS && found_ff) begin
         valid_ff[hit_idx_ff] <= 1'b0;
      end
   end

   assign rd_valid = valid_ff[rd_idx_ff];

   // Scan accumulators: first hit, first free slot, least recently seen.
   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         found_ff    <= 1'b0;
         free_any_ff <= 1'b0;
         lru_any_ff  <= 1'b0;
      end else if (cmd.scan_eval) begin
         if (rd_valid && rd_data_ff.source == addr_ff && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (!rd_valid) begin
            if (!free_any_ff) begin
               free_any_ff <= 1'b1;
            end
         end else if (!lru_any_ff || rd_data_ff.last_seen < lru_time_ff) begin
            lru_any_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_eval) begin
         if (rd_valid && rd_data_ff.source == addr_ff && !found_ff) begin
            hit_idx_ff <= rd_idx_ff;
            hit_rec_ff <= rd_data_ff;
         end
         if (!rd_valid) begin
            if (!free_any_ff) begin
               free_idx_ff <= rd_idx_ff;
            end
         end else if (!lru_any_ff || rd_data_ff.last_seen < lru_time_ff) begin
            lru_idx_ff  <= rd_idx_ff;
            lru_time_ff <= rd_data_ff.last_seen;
         end
      end
   end

   always_comb begin
      fresh_rec              = '0;
      fresh_rec.source       = addr_ff;
      fresh_rec.window_start = now_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         tgt_idx_ff  <= found_ff ? hit_idx_ff : (free_any_ff ? free_idx_ff : lru_idx_ff);
         work_rec_ff <= found_ff ? hit_rec_ff : fresh_rec;
         allowed_ff  <= !(op_ff == pfll_pkg::CMD_CHECK && max_att_ff != 8'd0 &&
                          found_ff && hit_rec_ff.lockout_end > now_ff);
      end
      if (cmd.upd1) begin
         gt_ff   <= now_ff > work_rec_ff.window_start;
         diff_ff <= now_ff - work_rec_ff.window_start;
      end
   end

   // Failure update of the target entry.
   always_comb begin
      restart    = gt_ff && (diff_ff > TW'(win_span_ff));
      base_count = restart ? 8'd0 : work_rec_ff.strikes;
      new_count  = (base_count == pfll_pkg::COUNT_MAX) ? base_count : base_count + 8'd1;
      new_rec              = work_rec_ff;
      new_rec.window_start = restart ? now_ff : work_rec_ff.window_start;
      new_rec.strikes      = new_count;
      new_rec.last_seen    = now_ff;
      if (new_count >= max_att_ff) begin
         new_rec.lockout_end = lock_end_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_allowed_ff <= allowed_ff;
         rsp_found_ff   <= found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_allowed     = rsp_allowed_ff;
   assign rsp_entry_found = rsp_found_ff;

   assign status.op       = op_ff;
   assign status.enabled  = (max_att_ff != 8'd0);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

// ===== rtl/pfll_ctrl.sv =====
// ----------------------------------------------------------------------------
// Limiter controller
// Sequences the table scan, the decision, the entry update and the
// response load for one request at a time.
// ----------------------------------------------------------------------------
module pfll_ctrl #(
   parameter int NUM_SLOTS = pfll_pkg::NUM_SLOTS_DEF,
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pfll_pkg::dp_status_type status,
   output pfll_pkg::dp_cmd_type    cmd,
   output logic [IDX_W-1:0]        scan_addr
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN      = 3'd1;
   localparam logic [2:0] ST_SCAN_LAST = 3'd2;
   localparam logic [2:0] ST_DECIDE    = 3'd3;
   localparam logic [2:0] ST_UPD1      = 3'd4;
   localparam logic [2:0] ST_UPD2      = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en     = 1'b1;
            cmd.scan_eval = (cnt_ff != '0);
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_SCAN_LAST;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_SCAN_LAST: begin
            cmd.scan_eval = 1'b1;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.pick = 1'b1;
            if (status.op == pfll_pkg::CMD_FAIL && status.enabled) begin
               state_in = ST_UPD1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPD1: begin
            cmd.upd1 = 1'b1;
            state_in = ST_UPD2;
         end
         ST_UPD2: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign scan_addr = cnt_ff;

endmodule

// ===== rtl/pfll_checker.sv =====
// ----------------------------------------------------------------------------
// Limiter port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module pfll_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_allowed,
   input logic rsp_entry_found
);

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed) &&
                                  $stable(rsp_entry_found))
      else $error("stalled response changed");

   // Reset leaves the block ready with no response pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // Only one request is worked on at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A response cannot appear the cycle after a request is accepted.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too early");

endmodule

bind per_source_failure_lockout_limiter pfll_checker u_pfll_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_allowed     (rsp_ch.allowed),
   .rsp_entry_found (rsp_ch.entry_found)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockout limiter testbench
// Drives check, failure, success and unused commands into the limiter under
// several register settings, predicts every response with an independent
// model of the source table, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SLOTS = pfll_pkg::NUM_SLOTS_DEF;

   // Watchdog: cycles without any transfer before the run is declared hung.
   // The longest legal quiet stretch is the receiver hold-off plus drain
   // and register writes, so this leaves a wide margin.
   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam logic [63:0] US_PER_SEC = 64'd1000000;

   // Codes the package does not name.
   localparam logic [1:0]                     CMD_UNUSED = 2'd3;
   localparam logic [pfll_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_type;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] addr;
      logic [63:0] now;
   } attempt_type;

   typedef struct {
      bit allowed;
      bit found;
   } verdict_type;

   // One row of the predicted source table.
   typedef struct {
      bit          in_use;
      logic [31:0] source;
      logic [63:0] win_start;
      logic [7:0]  fails;
      logic [63:0] last_seen;
      logic [63:0] lock_end;
   } source_row_type;

   logic clock;
   logic reset;
   logic                           csr_wr_en;
   logic [pfll_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pfll_pkg::CSR_W-1:0]     csr_wdata;

   pfll_req_if req_ch ();
   pfll_rsp_if rsp_ch ();

   per_source_failure_lockout_limiter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor state: the register copies and the source table.
   logic [7:0]  lim_max;
   logic [15:0] lim_window;
   logic [15:0] lim_lockout;
   source_row_type src_table [SLOTS];

   attempt_type pending_attempts[$];
   verdict_type awaited_verdicts[$];

   int attempts_queued;
   int attempts_taken;
   int verdicts_seen;
   int mismatches;
   int errors;
   int refusals;
   int evictions;
   int saturations;
   int settings_used;
   int idle_cycles;

   // Stimulus bookkeeping.
   logic [63:0] now_cursor;
   bit          req_taken;
   int          burst_left;
   int          gap_left;
   attempt_type next_attempt;

   // Receiver bookkeeping.
   bit          hold_request;
   int          long_hold;
   int          rx_cycle;
   rx_mode_type rx_mode;

   // Applies one request to the predicted table and returns the response
   // the limiter owes for it.
   function automatic verdict_type judge_attempt(input attempt_type a);
      verdict_type v;
      int          hit;
      int          slot;
      bit          free_seen;
      logic [63:0] span;
      hit = -1;
      free_seen = 0;
      span = 64'(lim_window) * US_PER_SEC;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && src_table[i].in_use && src_table[i].source == a.addr) begin
            hit = i;
         end
      end
      v.found = (hit >= 0);
      v.allowed = 1'b1;
      case (a.cmd)
         pfll_pkg::CMD_CHECK: begin
            if (lim_max != 8'd0 && hit >= 0 && src_table[hit].lock_end > a.now) begin
               v.allowed = 1'b0;
               refusals++;
            end
         end
         pfll_pkg::CMD_FAIL: begin
            if (lim_max != 8'd0) begin
               slot = hit;
               if (slot < 0) begin
                  // First free row wins; otherwise the stalest row, lowest index on ties.
                  slot = 0;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!free_seen) begin
                        if (!src_table[i].in_use) begin
                           slot = i;
                           free_seen = 1;
                        end else if (src_table[i].last_seen < src_table[slot].last_seen) begin
                           slot = i;
                        end
                     end
                  end
                  if (!free_seen) evictions++;
                  src_table[slot].in_use = 1;
                  src_table[slot].source = a.addr;
                  src_table[slot].win_start = a.now;
                  src_table[slot].fails = 8'd0;
                  src_table[slot].last_seen = 64'd0;
                  src_table[slot].lock_end = 64'd0;
               end
               if (a.now > src_table[slot].win_start &&
                   a.now - src_table[slot].win_start > span) begin
                  src_table[slot].win_start = a.now;
                  src_table[slot].fails = 8'd0;
               end
               if (src_table[slot].fails != 8'hFF) begin
                  src_table[slot].fails++;
               end else begin
                  saturations++;
               end
               src_table[slot].last_seen = a.now;
               if (src_table[slot].fails >= lim_max) begin
                  src_table[slot].lock_end = a.now + 64'(lim_lockout) * US_PER_SEC;
               end
            end
         end
         pfll_pkg::CMD_SUCCESS: begin
            if (hit >= 0) src_table[hit].in_use = 0;
         end
         default: ;
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. Items come from the pending queue in bursts of random
   // length separated by random gaps; a gap of zero gives stretches where the
   // limiter is offered a new request on every cycle it can take one.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         // Hold the offered request until it is taken.
      end else if (gap_left > 0) begin
         gap_left--;
         req_ch.valid <= 1'b0;
      end else if (pending_attempts.size() > 0) begin
         next_attempt = pending_attempts.pop_front();
         req_ch.valid       <= 1'b1;
         req_ch.cmd         <= next_attempt.cmd;
         req_ch.source_addr <= next_attempt.addr;
         req_ch.now_time    <= next_attempt.now;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
      req_taken = 0;
   end

   // ------------------------------------------------------------------------
   // Response receiver. It switches between always ready, coin flips, a fixed
   // pattern and a heavy stall. On request from the stimulus it holds off for
   // a long stretch so the response register fills and the input backs up.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_request) begin
            long_hold = LONG_HOLD_CYCLES;
            hold_request = 0;
         end
         rx_cycle++;
         if (long_hold > 0) begin
            long_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (rx_cycle % 97 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
            case (rx_mode)
               RX_OPEN:    rsp_ch.ready <= 1'b1;
               RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_PATTERN: rsp_ch.ready <= (rx_cycle % 5 != 0) && (rx_cycle % 7 != 3);
               default:    rsp_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Responses are compared with the oldest prediction; an accepted
   // request is run through the predictor at the edge that transfers it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      attempt_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            verdicts_seen++;
            if (awaited_verdicts.size() == 0) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with no request outstanding", verdicts_seen);
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_ch.allowed !== want.allowed || rsp_ch.entry_found !== want.found) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d: allowed exp %0b got %0b, entry_found exp %0b got %0b",
                              verdicts_seen, want.allowed, rsp_ch.allowed,
                              want.found, rsp_ch.entry_found);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.cmd = req_ch.cmd;
            seen.addr = req_ch.source_addr;
            seen.now = req_ch.now_time;
            awaited_verdicts.push_back(judge_attempt(seen));
            attempts_taken++;
            req_taken = 1;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic queue_attempt(input logic [1:0] c, input logic [31:0] a,
                                input logic [63:0] t);
      attempt_type x;
      x.cmd = c;
      x.addr = a;
      x.now = t;
      pending_attempts.push_back(x);
      attempts_queued++;
   endtask

   // Register write; the predictor copy follows once the write edge is past.
   task automatic csr_write(input logic [pfll_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pfll_pkg::CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         pfll_pkg::CSR_MAX_ATTEMPTS:    lim_max = data[7:0];
         pfll_pkg::CSR_WINDOW_SECONDS:  lim_window = data;
         pfll_pkg::CSR_LOCKOUT_SECONDS: lim_lockout = data;
         default: ;
      endcase
   endtask

   // The upper byte of the attempt limit write carries noise the block must
   // drop, and a write to the unused index must change nothing.
   task automatic set_limits(input logic [7:0] max_fail, input logic [15:0] win,
                             input logic [15:0] lock);
      csr_write(pfll_pkg::CSR_MAX_ATTEMPTS, {8'($urandom), max_fail});
      csr_write(pfll_pkg::CSR_WINDOW_SECONDS, win);
      csr_write(pfll_pkg::CSR_LOCKOUT_SECONDS, lock);
      csr_write(CSR_UNUSED, 16'($urandom));
      settings_used++;
   endtask

   // Waits until every queued request was taken and answered, then lets the
   // pipeline settle before anything else happens.
   task automatic wait_quiet();
      while (!(pending_attempts.size() == 0 && attempts_taken == attempts_queued &&
               awaited_verdicts.size() == 0))
         @(negedge clock);
      repeat (SLOTS + 8) @(negedge clock);
   endtask

   // Moves the simulated wall clock: mostly small forward steps, now and then
   // a jump back in time or a jump past the whole window.
   task automatic advance_time(input int step_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         now_cursor = now_cursor - 64'($urandom_range(0, step_max)) * 64'd50;
      else if (r < 6)
         now_cursor = now_cursor + 64'(lim_window) * US_PER_SEC + 64'($urandom_range(0, step_max));
      else
         now_cursor = now_cursor + 64'($urandom_range(0, step_max));
   endtask

   // Random traffic. Most of it is attack runs: one source failing a random
   // number of times around the limit, then a check, sometimes a success.
   // The rest is single commands, including unknown sources and the unused code.
   task automatic attack_phase(input int n, input int pool_size, input int step_max,
                               input logic [63:0] start_time);
      logic [31:0] pool [32];
      logic [31:0] who;
      logic [1:0]  c;
      int          made;
      int          k;
      int          r;
      now_cursor = start_time;
      for (int i = 0; i < 32; i++) pool[i] = $urandom;
      made = 0;
      while (made < n) begin
         who = pool[$urandom_range(0, pool_size - 1)];
         if ($urandom_range(0, 9) < 6) begin
            k = $urandom_range(1, int'(lim_max) + 2);
            for (int j = 0; j < k && made < n; j++) begin
               advance_time(step_max);
               queue_attempt(pfll_pkg::CMD_FAIL, who, now_cursor);
               made++;
            end
            if (made < n) begin
               advance_time(step_max);
               queue_attempt(pfll_pkg::CMD_CHECK, who, now_cursor);
               made++;
            end
            if (made < n && $urandom_range(0, 3) == 0) begin
               advance_time(step_max);
               queue_attempt(pfll_pkg::CMD_SUCCESS, who, now_cursor);
               made++;
            end
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40)      c = pfll_pkg::CMD_CHECK;
            else if (r < 80) c = pfll_pkg::CMD_FAIL;
            else if (r < 94) c = pfll_pkg::CMD_SUCCESS;
            else             c = CMD_UNUSED;
            if ($urandom_range(0, 99) < 15) who = $urandom;
            advance_time(step_max);
            queue_attempt(c, who, now_cursor);
            made++;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = pfll_pkg::CMD_CHECK;
      req_ch.source_addr = '0;
      req_ch.now_time = '0;
      rsp_ch.ready = 1'b0;
      hold_request = 0;
      long_hold = 0;
      rx_cycle = 0;
      rx_mode = RX_OPEN;
      burst_left = 1;
      gap_left = 0;
      req_taken = 0;
      // Predictor copy of the reset state.
      lim_max = pfll_pkg::MAX_ATTEMPTS_RST;
      lim_window = pfll_pkg::WINDOW_SECONDS_RST;
      lim_lockout = pfll_pkg::LOCKOUT_SECONDS_RST;
      for (int i = 0; i < SLOTS; i++) begin
         src_table[i].in_use = 0;
         src_table[i].source = '0;
         src_table[i].win_start = '0;
         src_table[i].fails = '0;
         src_table[i].last_seen = '0;
         src_table[i].lock_end = '0;
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset defaults (5 failures, 30 s, 60 s).
      // Unknown source at address zero, at both ends of the time range.
      queue_attempt(pfll_pkg::CMD_CHECK, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_attempt(pfll_pkg::CMD_CHECK, 32'h0000_0000, 64'd0);
      // Five failures lock the source out until 64 s.
      for (int i = 0; i < 5; i++)
         queue_attempt(pfll_pkg::CMD_FAIL, 32'hFFFF_FFFF, 64'(i) * US_PER_SEC);
      queue_attempt(pfll_pkg::CMD_CHECK, 32'hFFFF_FFFF, 64'd5_000_000);
      // The lockout ends exactly at its end time, not one microsecond later.
      queue_attempt(pfll_pkg::CMD_CHECK, 32'hFFFF_FFFF, 64'd64_000_000);
      queue_attempt(pfll_pkg::CMD_CHECK, 32'hFFFF_FFFF, 64'd63_999_999);
      queue_attempt(CMD_UNUSED, 32'hFFFF_FFFF, 64'd1);
      // A success frees the entry; a second success finds nothing.
      queue_attempt(pfll_pkg::CMD_SUCCESS, 32'hFFFF_FFFF, 64'd70_000_000);
      queue_attempt(pfll_pkg::CMD_SUCCESS, 32'hFFFF_FFFF, 64'd70_000_001);
      queue_attempt(pfll_pkg::CMD_CHECK, 32'hFFFF_FFFF, 64'd70_000_002);
      // Window restart: exactly one window later still counts, one
      // microsecond more restarts, and an earlier time never restarts.
      queue_attempt(pfll_pkg::CMD_FAIL, 32'h0000_0001, 64'd100_000_000);
      queue_attempt(pfll_pkg::CMD_FAIL, 32'h0000_0001, 64'd130_000_000);
      queue_attempt(pfll_pkg::CMD_FAIL, 32'h0000_0001, 64'd130_000_001);
      queue_attempt(pfll_pkg::CMD_FAIL, 32'h0000_0001, 64'd50);
      // Fill the table; the ninth source pushes out the stalest row.
      for (int i = 0; i < SLOTS; i++)
         queue_attempt(pfll_pkg::CMD_FAIL, 32'h5A5A_5A50 + 32'(i),
                       64'd200_000_000 + 64'(i));
      queue_attempt(pfll_pkg::CMD_CHECK, 32'h0000_0001, 64'd200_000_100);
      wait_quiet();

      // Defaults rewritten; the receiver holds off for a long stretch while
      // the sender keeps offering, so the limiter backs up its input.
      set_limits(8'd5, 16'd30, 16'd60);
      attack_phase(200, 12, 500_000, 64'd1_000_000);
      hold_request = 1;
      wait_quiet();

      // One failure locks out for the longest time; the window never holds.
      set_limits(8'd1, 16'd0, 16'd65535);
      attack_phase(150, 10, 2_000_000, {32'($urandom), 32'($urandom)});
      wait_quiet();

      // Limiter disabled: checks always pass, failures leave the table alone.
      set_limits(8'd0, 16'd65535, 16'd65535);
      attack_phase(100, 10, 1_000_000, 64'd0);
      wait_quiet();

      // Highest limit with a long window on two sources: counts saturate.
      set_limits(8'd255, 16'd65535, 16'd1);
      attack_phase(300, 2, 1_000, 64'd5_000_000);
      wait_quiet();

      // Times just below the top of the range, so times and lockout ends wrap.
      set_limits(8'd3, 16'd10, 16'd20);
      attack_phase(150, 9, 400_000, 64'hFFFF_FFFF_FFFF_FFFF - 64'd40_000_000);
      wait_quiet();

      // Small random settings with more sources than rows.
      set_limits(8'($urandom_range(1, 8)), 16'($urandom_range(0, 100)),
                 16'($urandom_range(0, 200)));
      attack_phase(200, 16, 1_000_000, {32'($urandom), 32'($urandom)});
      wait_quiet();

      // Zero lockout: the end time equals the failure time, so only a check stamped before it is refused.
      set_limits(8'd2, 16'd65535, 16'd0);
      attack_phase(150, 10, 3_000_000, 64'd1);
      wait_quiet();

      repeat (2 * SLOTS + 10) @(negedge clock);
      if (awaited_verdicts.size() != 0) begin
         errors++;
         $display("%0d responses never arrived", awaited_verdicts.size());
      end
      $display("covered %0d requests and %0d responses over %0d register settings",
               attempts_taken, verdicts_seen, settings_used);
      $display("lockout refusals %0d, evictions %0d, saturated failures %0d, mismatches %0d",
               refusals, evictions, saturations, mismatches);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
